// ===== rtl/ssdfb_pkg.sv =====
package ssdfb_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES = 8;
  localparam int ROWS = PAGES * 8;
  localparam int DEPTH = PAGES * COLUMNS;
  localparam int COL_W = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [7:0] MAX_DIGIT = 8'd9;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_DIGIT = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  localparam int SEG_T  = 0;
  localparam int SEG_B  = 1;
  localparam int SEG_C  = 2;
  localparam int SEG_LT = 3;
  localparam int SEG_LB = 4;
  localparam int SEG_RT = 5;
  localparam int SEG_RB = 6;

  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h7B, 7'h60, 7'h37, 7'h67, 7'h6C, 7'h4F, 7'h5F, 7'h61, 7'h7F, 7'h6F
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] value;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] line_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ignored;
  } out_item_t;

  typedef struct packed {
    in_item_t          item;
    logic [COL_W-1:0]  col;
    logic [PAGE_W-1:0] page;
  } paint_req_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] bits;
  } paint_t;

  function automatic logic [6:0] seg_lookup(logic [7:0] digit);
    logic [6:0] segs;
    segs = '0;
    if (digit <= MAX_DIGIT) begin
      segs = DIGIT_SEGS[digit[3:0]];
    end
    return segs;
  endfunction

endpackage

// ===== rtl/ssdfb_in_if.sv =====
interface ssdfb_in_if;
  logic                 valid;
  logic                 ready;
  ssdfb_pkg::in_item_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ssdfb_out_if.sv =====
interface ssdfb_out_if;
  logic                 valid;
  logic                 ready;
  ssdfb_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/seven_segment_digit_framebuffer.sv =====
// Page-mode monochrome framebuffer of COLUMNS by PAGES*8 pixels with seven-segment digit
// painting, built around a single-port byte store and one read-modify-write sequencer.
// After reset the store is cleared one byte per cycle, over all DEPTH bytes (1024 at 128
// by 8), and no transfer is taken meanwhile. A pixel write reads its byte, writes it
// back and then returns its result; a column read reads the byte and returns it, and a
// dropped request goes straight to its result. A digit reads and then writes every column
// byte its clipped box covers through the store port, page by page within each column.
// The store port and the byte painter are shared by all requests, so one request is
// worked at a time; a finished result waits in an output register while the next
// request is taken.
module seven_segment_digit_framebuffer (
  input logic        clk_i,
  input logic        rst_ni,
  ssdfb_in_if.sink   in_i,
  ssdfb_out_if.source out_o
);

  localparam int AW = ssdfb_pkg::ADDR_W;
  localparam int CW = ssdfb_pkg::COL_W;
  localparam int PW = ssdfb_pkg::PAGE_W;

  ssdfb_pkg::state_e   state_q, state_d;
  ssdfb_pkg::in_item_t item_q, item_d;
  logic [CW-1:0]       col_q, col_d, col_last_q, col_last_d;
  logic [PW-1:0]       page_q, page_d, page_last_q, page_last_d, page_first_q, page_first_d;
  logic                ign_q, ign_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  ssdfb_pkg::out_item_t out_data_q, out_data_d;

  logic [7:0]          mem [ssdfb_pkg::DEPTH];
  logic [7:0]          rdata_q;
  logic [AW-1:0]       mem_addr;
  logic                mem_we, mem_re;
  logic [7:0]          mem_wdata;

  ssdfb_pkg::paint_req_t req;
  ssdfb_pkg::paint_t     paint;

  logic [8:0] in_x9, in_y9, x_end9, y_end9, col_lim9, row_lim9;

  assign req.item = item_q;
  assign req.col  = col_q;
  assign req.page = page_q;

  ssdfb_paint u_paint (
    .req_i   (req),
    .paint_o (paint)
  );

  assign in_x9    = {1'b0, in_i.data.x};
  assign in_y9    = {1'b0, in_i.data.y};
  assign x_end9   = in_x9 + {1'b0, in_i.data.width} - 9'd1;
  assign y_end9   = in_y9 + {1'b0, in_i.data.height} - 9'd1;
  assign col_lim9 = (x_end9 < 9'(ssdfb_pkg::COLUMNS)) ? x_end9 : 9'(ssdfb_pkg::COLUMNS - 1);
  assign row_lim9 = (y_end9 < 9'(ssdfb_pkg::ROWS)) ? y_end9 : 9'(ssdfb_pkg::ROWS - 1);

  assign in_i.ready = (state_q == ssdfb_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign mem_addr = (state_q == ssdfb_pkg::ST_CLEAR) ? clr_q :
                    AW'(AW'(page_q) * AW'(ssdfb_pkg::COLUMNS) + AW'(col_q));
  assign mem_re    = (state_q == ssdfb_pkg::ST_READ);
  assign mem_we    = (state_q == ssdfb_pkg::ST_CLEAR) || (state_q == ssdfb_pkg::ST_WRITE);
  assign mem_wdata = (state_q == ssdfb_pkg::ST_CLEAR) ? 8'd0 :
                     ((rdata_q & ~paint.mask) | (paint.bits & paint.mask));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssdfb_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    col_q        <= col_d;
    col_last_q   <= col_last_d;
    page_q       <= page_d;
    page_first_q <= page_first_d;
    page_last_q  <= page_last_d;
    ign_q        <= ign_d;
    out_data_q   <= out_data_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    item_d       = item_q;
    col_d        = col_q;
    col_last_d   = col_last_q;
    page_d       = page_q;
    page_first_d = page_first_q;
    page_last_d  = page_last_q;
    ign_d        = ign_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    case (state_q)
      ssdfb_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(ssdfb_pkg::DEPTH - 1)) begin
          state_d = ssdfb_pkg::ST_IDLE;
        end
      end
      ssdfb_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          item_d       = in_i.data;
          col_d        = CW'(in_i.data.x);
          col_last_d   = CW'(col_lim9);
          page_d       = in_i.data.y[PW+2:3];
          page_first_d = in_i.data.y[PW+2:3];
          page_last_d  = row_lim9[PW+2:3];
          ign_d        = 1'b1;
          state_d      = ssdfb_pkg::ST_FINISH;
          case (in_i.data.mode)
            ssdfb_pkg::MODE_PIXEL: begin
              if (in_x9 < 9'(ssdfb_pkg::COLUMNS) && in_y9 < 9'(ssdfb_pkg::ROWS)) begin
                ign_d   = 1'b0;
                state_d = ssdfb_pkg::ST_READ;
              end
            end
            ssdfb_pkg::MODE_DIGIT: begin
              if (in_i.data.value <= ssdfb_pkg::MAX_DIGIT) begin
                ign_d = 1'b0;
                if (in_i.data.width != 8'd0 && in_i.data.height != 8'd0 &&
                    in_x9 < 9'(ssdfb_pkg::COLUMNS) && in_y9 < 9'(ssdfb_pkg::ROWS)) begin
                  state_d = ssdfb_pkg::ST_READ;
                end
              end
            end
            ssdfb_pkg::MODE_READ: begin
              page_d = PW'(in_i.data.y);
              if (in_x9 < 9'(ssdfb_pkg::COLUMNS) && in_y9 < 9'(ssdfb_pkg::PAGES)) begin
                ign_d   = 1'b0;
                state_d = ssdfb_pkg::ST_READ;
              end
            end
            default: begin
              ign_d = 1'b1;
            end
          endcase
        end
      end
      ssdfb_pkg::ST_READ: begin
        if (item_q.mode == ssdfb_pkg::MODE_READ) begin
          state_d = ssdfb_pkg::ST_FINISH;
        end else begin
          state_d = ssdfb_pkg::ST_WRITE;
        end
      end
      ssdfb_pkg::ST_WRITE: begin
        state_d = ssdfb_pkg::ST_READ;
        if (item_q.mode != ssdfb_pkg::MODE_DIGIT) begin
          state_d = ssdfb_pkg::ST_FINISH;
        end else if (page_q != page_last_q) begin
          page_d = page_q + PW'(1);
        end else if (col_q != col_last_q) begin
          col_d  = col_q + CW'(1);
          page_d = page_first_q;
        end else begin
          state_d = ssdfb_pkg::ST_FINISH;
        end
      end
      ssdfb_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d          = 1'b1;
          out_data_d.ignored   = ign_q;
          out_data_d.read_data =
            (item_q.mode == ssdfb_pkg::MODE_READ && !ign_q) ? rdata_q : 8'd0;
          state_d              = ssdfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssdfb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ssdfb_paint.sv =====
module ssdfb_paint (
  input  ssdfb_pkg::paint_req_t req_i,
  output ssdfb_pkg::paint_t     paint_o
);

  logic [6:0] segs;
  logic [8:0] x9, y9, w9, h9, lw9, half9, lwh9, dx9;
  logic       left, right;
  logic [8:0] row9 [8];
  logic [8:0] dy9 [8];
  logic [7:0] in_box, on;

  assign segs  = ssdfb_pkg::seg_lookup(req_i.item.value);
  assign x9    = {1'b0, req_i.item.x};
  assign y9    = {1'b0, req_i.item.y};
  assign w9    = {1'b0, req_i.item.width};
  assign h9    = {1'b0, req_i.item.height};
  assign lw9   = {1'b0, req_i.item.line_width};
  assign half9 = h9 >> 1;
  assign lwh9  = lw9 >> 1;
  assign dx9   = 9'(req_i.col) - x9;
  assign left  = dx9 < lw9;
  assign right = (dx9 + lw9) >= w9;

  always_comb begin
    logic top, bottom, upper, centre;
    paint_o = '0;
    for (int k = 0; k < 8; k++) begin
      row9[k] = 9'({req_i.page, 3'(k)});
      dy9[k] = row9[k] - y9;
      in_box[k] = (row9[k] >= y9) && (row9[k] < (y9 + h9));
      top = dy9[k] < lw9;
      bottom = (dy9[k] + lw9) >= h9;
      upper = dy9[k] < half9;
      if (lw9 > 9'd1) begin
        centre = ((dy9[k] + lwh9) >= half9) && (dy9[k] < (half9 + lwh9));
      end else begin
        centre = dy9[k] == half9;
      end
      on[k] = (segs[ssdfb_pkg::SEG_T] && top) ||
              (segs[ssdfb_pkg::SEG_B] && bottom) ||
              (segs[ssdfb_pkg::SEG_C] && centre) ||
              (segs[ssdfb_pkg::SEG_LT] && left && upper) ||
              (segs[ssdfb_pkg::SEG_LB] && left && !upper) ||
              (segs[ssdfb_pkg::SEG_RT] && right && upper) ||
              (segs[ssdfb_pkg::SEG_RB] && right && !upper);
    end
    case (req_i.item.mode)
      ssdfb_pkg::MODE_PIXEL: begin
        paint_o.mask = 8'(1) << req_i.item.y[2:0];
        paint_o.bits = (req_i.item.value == 8'd1) ? paint_o.mask : 8'd0;
      end
      ssdfb_pkg::MODE_DIGIT: begin
        paint_o.mask = in_box;
        paint_o.bits = on & in_box;
      end
      default: begin
        paint_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/ssdfb_checker.sv =====
module ssdfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_read_data_i,
  input logic       out_ignored_i
);

  // The block works one request at a time, so a transfer makes it busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  a_ignored_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ignored_i |-> out_read_data_i == 8'd0)
    else $error("dropped request returned data");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_read_data_i) && $stable(out_ignored_i))
    else $error("stalled result changed");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result shown in the cycle after a transfer");

endmodule

bind seven_segment_digit_framebuffer ssdfb_checker u_ssdfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.data.read_data),
  .out_ignored_i   (out_o.data.ignored)
);
